>>> rtl/skb_pkg.sv
// Package for the SKINNY-128-256 block decryption core.
// Holds widths, the controller state type, the control struct and round functions.
// No dependencies.
package skb_pkg;

  localparam int Rounds = 48;
  localparam int RndW   = 6;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic            load_key;
    logic [RndW-1:0] key_idx;
    logic            start;
    logic            rd_en;
    logic [RndW-1:0] rd_idx;
    logic            round_en;
    logic            last_round;
  } ctrl_t;

  function automatic logic [7:0] sb_mix(input logic [7:0] x);
    logic [7:0] y;
    y = x;
    y[4] = y[4] ^ ~(y[7] | y[6]);
    y[0] = y[0] ^ ~(y[3] | y[2]);
    return y;
  endfunction

  function automatic logic [7:0] sb_unperm(input logic [7:0] b);
    logic [7:0] x;
    x[2] = b[7];
    x[1] = b[6];
    x[7] = b[5];
    x[6] = b[4];
    x[4] = b[3];
    x[0] = b[2];
    x[3] = b[1];
    x[5] = b[0];
    return x;
  endfunction

  function automatic logic [7:0] sbox_dec(input logic [7:0] v);
    logic [7:0] y;
    y = {v[7:3], v[1], v[2], v[0]};
    y = sb_mix(y);
    for (int k = 0; k < 3; k++) begin
      y = sb_mix(sb_unperm(y));
    end
    return y;
  endfunction

  // Forward step of the six-bit round-constant LFSR.
  function automatic logic [5:0] rc_next(input logic [5:0] s);
    return {s[4:0], ~(s[5] ^ s[4])};
  endfunction

  // Inverse LFSR step: walk the constant back one round.
  function automatic logic [5:0] rc_prev(input logic [5:0] s);
    return {~(s[0] ^ s[5]), s[5:1]};
  endfunction

  function automatic logic [5:0] rc_last();
    logic [5:0] s;
    s = '0;
    for (int r = 0; r < Rounds; r++) begin
      s = rc_next(s);
    end
    return s;
  endfunction

endpackage

>>> rtl/skinny128_256_block_decrypt.sv
// SKINNY-128-256 block decryption core, one inverse round per cycle.
// Load requests return nothing; a decrypt request runs all 48 inverse rounds, then
// raises tvalid and holds the result until it is taken.
// tready returns the cycle after the result is taken, so a new request is accepted only
// once the previous decrypt has finished; the tweakey memory is read one round ahead.
// rst_ni is asynchronous, active low; the tweakey memory is not cleared.
module skinny128_256_block_decrypt import skb_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [135:0] s_axis_tdata_i,  // round_index[5:0], word_hi[69:6], word_lo[133:70]
  input  logic         s_axis_tuser_i,  // func
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [127:0] m_axis_tdata_o   // plain_hi[63:0], plain_lo[127:64]
);

  ctrl_t        ctrl;
  logic [127:0] plain;

  skb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_func_i   (s_axis_tuser_i),
    .in_round_i  (s_axis_tdata_i[5:0]),
    .out_ready_i (m_axis_tready_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .ctrl_o      (ctrl)
  );

  skb_datapath u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctrl_i    (ctrl),
    .word_hi_i (s_axis_tdata_i[69:6]),
    .word_lo_i (s_axis_tdata_i[133:70]),
    .plain_o   (plain)
  );

  assign m_axis_tdata_o = {plain[63:0], plain[127:64]};

endmodule

>>> rtl/skb_ctrl.sv
// Controller for the SKINNY-128-256 decryption core.
// Sequences key loads, the round loop and the result handshake. Uses skb_pkg.
module skb_ctrl import skb_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_func_i,
  input  logic [RndW-1:0] in_round_i,
  input  logic            out_ready_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  output ctrl_t           ctrl_o
);

  state_e          state_q, state_d;
  logic [RndW-1:0] rnd_q, rnd_d;
  logic            acc;

  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    rnd_d   = rnd_q;
    case (state_q)
      ST_IDLE: begin
        if (acc && in_func_i) begin
          state_d = ST_RUN;
          rnd_d   = RndW'(Rounds - 1);
        end
      end
      ST_RUN: begin
        if (rnd_q == '0) begin
          state_d = ST_OUT;
        end else begin
          rnd_d = rnd_q - 1'b1;
        end
      end
      ST_OUT: begin
        if (out_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o         = (state_q == ST_IDLE);
    out_valid_o        = (state_q == ST_OUT);
    ctrl_o             = '0;
    ctrl_o.load_key    = acc && !in_func_i && (in_round_i < RndW'(Rounds));
    ctrl_o.key_idx     = in_round_i;
    ctrl_o.start       = acc && in_func_i;
    ctrl_o.rd_en       = (acc && in_func_i) || (state_q == ST_RUN && rnd_q != '0);
    ctrl_o.rd_idx      = (state_q == ST_RUN) ? rnd_q - 1'b1 : RndW'(Rounds - 1);
    ctrl_o.round_en    = (state_q == ST_RUN);
    ctrl_o.last_round  = (state_q == ST_RUN) && (rnd_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      rnd_q   <= '0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !in_ready_o) else $error("accept while busy");
  a_run_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.last_round |=> out_valid_o) else $error("missing result");
  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.start |=> (state_q == ST_RUN && rnd_q == RndW'(Rounds - 1)))
    else $error("bad start");

endmodule

>>> rtl/skb_datapath.sv
// Datapath for the SKINNY-128-256 decryption core: tweakey memory,
// state register and one inverse round per cycle. Uses skb_pkg.
module skb_datapath import skb_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  ctrl_t         ctrl_i,
  input  logic [63:0]   word_hi_i,
  input  logic [63:0]   word_lo_i,
  output logic [127:0]  plain_o
);

  logic [63:0]  tk_mem [Rounds];
  logic [63:0]  key_q;
  logic [127:0] st_q, st_d;
  logic [5:0]   rc_q, rc_d;
  logic [7:0]   s [16];
  logic [7:0]   t [16];
  logic [7:0]   u [16];
  logic [127:0] rnd_out;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_key) begin
      tk_mem[ctrl_i.key_idx] <= word_hi_i ^ word_lo_i;
    end
    if (ctrl_i.rd_en) begin
      key_q <= tk_mem[ctrl_i.rd_idx];
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s[i] = st_q[127-8*i -: 8];
    end
    for (int i = 0; i < 4; i++) begin
      t[i]    = s[4+i];
      t[4+i]  = s[4+i] ^ s[8+i] ^ s[12+i];
      t[8+i]  = s[4+i] ^ s[12+i];
      t[12+i] = s[i] ^ s[12+i];
    end
    u[0] = t[0];   u[1] = t[1];   u[2] = t[2];   u[3] = t[3];
    u[4] = t[5];   u[5] = t[6];   u[6] = t[7];   u[7] = t[4];
    u[8] = t[10];  u[9] = t[11];  u[10] = t[8];  u[11] = t[9];
    u[12] = t[15]; u[13] = t[12]; u[14] = t[13]; u[15] = t[14];
    for (int i = 0; i < 8; i++) begin
      u[i] = u[i] ^ key_q[63-8*i -: 8];
    end
    u[0] = u[0] ^ {4'h0, rc_q[3:0]};
    u[4] = u[4] ^ {6'h0, rc_q[5:4]};
    u[8] = u[8] ^ 8'h02;
    for (int i = 0; i < 16; i++) begin
      rnd_out[127-8*i -: 8] = sbox_dec(u[i]);
    end
  end

  always_comb begin
    st_d = st_q;
    rc_d = rc_q;
    if (ctrl_i.start) begin
      st_d = {word_hi_i, word_lo_i};
      rc_d = rc_last();
    end else if (ctrl_i.round_en) begin
      st_d = rnd_out;
      rc_d = rc_prev(rc_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rc_q <= '0;
    end else begin
      rc_q <= rc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  assign plain_o = st_q;

  a_rc_wraps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.last_round |=> (rc_q == 6'h00 || rc_q == rc_prev(6'h01)))
    else $error("round constant out of step");
  a_no_load_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.round_en |-> !ctrl_i.load_key) else $error("load during run");
  a_start_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |-> !ctrl_i.round_en) else $error("start during run");

endmodule

>>> tb/skinny128_256_block_decrypt_test.sv
// Testbench for skinny128_256_block_decrypt: drives load and decrypt requests on the
// input stream and checks each plaintext against a behavioral SKINNY-128-256 decryptor.
// Depends on skb_pkg and the block itself.
module skinny128_256_block_decrypt_test import skb_pkg::*;;

  localparam bit FnLoad    = 1'b0;
  localparam bit FnDecrypt = 1'b1;

  class plain_board;
    logic [63:0] tweakey [Rounds];
    logic [127:0] plain_q [$];
    int errors;

    function automatic logic [7:0] unmix(logic [7:0] x);
      logic [7:0] y;
      y = x;
      y[4] = y[4] ^ ~(y[7] | y[6]);
      y[0] = y[0] ^ ~(y[3] | y[2]);
      return y;
    endfunction

    function automatic logic [7:0] sbox_inv(logic [7:0] v);
      logic [7:0] y;
      y = {v[7:3], v[1], v[2], v[0]};
      y = unmix(y);
      for (int k = 0; k < 3; k++) begin
        y = unmix({v[0] ^ v[0] ^ y[5], y[4], y[0], y[3], y[1], y[7], y[6], y[2]});
      end
      return y;
    endfunction

    function automatic logic [127:0] decrypt(logic [63:0] hi, logic [63:0] lo);
      logic [7:0] s [16];
      logic [7:0] t [16];
      logic [5:0] rc [Rounds];
      logic [5:0] lf;
      int map [16] = '{0,1,2,3,5,6,7,4,10,11,8,9,15,12,13,14};
      lf = '0;
      for (int r = 0; r < Rounds; r++) begin
        lf = {lf[4:0], ~(lf[5] ^ lf[4])};
        rc[r] = lf;
      end
      for (int i = 0; i < 8; i++) begin
        s[i] = hi[63-8*i -: 8];
        s[8+i] = lo[63-8*i -: 8];
      end
      for (int r = Rounds - 1; r >= 0; r--) begin
        for (int i = 0; i < 4; i++) begin
          t[i] = s[4+i];
          t[4+i] = s[4+i] ^ s[8+i] ^ s[12+i];
          t[8+i] = s[4+i] ^ s[12+i];
          t[12+i] = s[i] ^ s[12+i];
        end
        for (int i = 0; i < 16; i++) s[i] = t[map[i]];
        for (int i = 0; i < 8; i++) s[i] ^= tweakey[r][63-8*i -: 8];
        s[0] ^= {4'h0, rc[r][3:0]};
        s[4] ^= {6'h0, rc[r][5:4]};
        s[8] ^= 8'h02;
        for (int i = 0; i < 16; i++) s[i] = sbox_inv(s[i]);
      end
      for (int i = 0; i < 8; i++) begin
        hi[63-8*i -: 8] = s[i];
        lo[63-8*i -: 8] = s[8+i];
      end
      return {lo, hi};
    endfunction

    function void note_request(bit fn, logic [5:0] idx, logic [63:0] hi, logic [63:0] lo);
      if (fn == FnLoad) begin
        if (idx < Rounds) begin
          tweakey[idx] = hi ^ lo;
        end
      end else begin
        plain_q.push_back(decrypt(hi, lo));
      end
    endfunction

    function void check_plain(logic [127:0] got);
      logic [127:0] exp;
      if (plain_q.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp = plain_q.pop_front();
      if (got[63:0] !== exp[63:0]) begin
        $display("%0t: plain_hi expected %h actual %h", $time, exp[63:0], got[63:0]);
        errors++;
      end
      if (got[127:64] !== exp[127:64]) begin
        $display("%0t: plain_lo expected %h actual %h", $time, exp[127:64], got[127:64]);
        errors++;
      end
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         s_axis_tvalid_i = 0;
  logic         s_axis_tready_o;
  logic [135:0] s_axis_tdata_i = '0;
  logic         s_axis_tuser_i = 0;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i = 0;
  logic [127:0] m_axis_tdata_o;

  plain_board board = new();
  bit   hold_off = 0;
  bit   all_sent = 0;
  int   cycles = 0;

  skinny128_256_block_decrypt uut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_request(bit fn, logic [5:0] idx, logic [63:0] hi, logic [63:0] lo);
    int gap;
    gap = $urandom_range(3) == 0 ? 0 : $urandom_range(16);
    if (gap != 0) begin
      s_axis_tvalid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1;
    s_axis_tuser_i <= fn;
    s_axis_tdata_i <= {2'b00, lo, hi, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
    board.note_request(fn, idx, hi, lo);
  endtask

  function automatic logic [63:0] rand64();
    case ($urandom_range(5))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic load_all();
    for (int r = 0; r < Rounds; r++) send_request(FnLoad, r[5:0], rand64(), rand64());
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 0;
    @(posedge clk_i);
    while (board.plain_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_axis_tready_i) board.check_plain(m_axis_tdata_o);
  end

  initial begin
    int stall;
    forever begin
      @(posedge clk_i);
      if (hold_off) begin
        m_axis_tready_i <= 0;
      end else if ($urandom_range(3) == 0) begin
        stall = $urandom_range(16, 1);
        m_axis_tready_i <= 0;
        repeat (stall) @(posedge clk_i);
        m_axis_tready_i <= 1;
      end else begin
        m_axis_tready_i <= 1;
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    load_all();
    send_request(FnLoad, 6'd48, '1, '0);
    send_request(FnLoad, 6'd63, '1, 64'h5);
    send_request(FnDecrypt, 6'd0, '0, '0);
    send_request(FnDecrypt, 6'd63, '1, '1);
    send_request(FnDecrypt, 6'd0, 64'h0123456789abcdef, 64'hfedcba9876543210);
    drain();
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      repeat (4) send_request(FnDecrypt, 6'($urandom), rand64(), rand64());
    join
    drain();
    for (int n = 0; n < 1800; n++) begin
      if ($urandom_range(3) == 0)
        send_request(FnLoad, 6'($urandom_range(Rounds + 15)), rand64(), rand64());
      else
        send_request(FnDecrypt, 6'($urandom), rand64(), rand64());
      if (n % 300 == 299) drain();
    end
    drain();
    repeat (60) @(posedge clk_i);
    if (board.errors == 0 && board.plain_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end
endmodule
